// ===== hdl/c2s_pkg.sv =====
// ----------------------------------------------------------------------------
// c2s_pkg
// Constants, types and the arctangent table for the cartesian to spherical
// conversion pipeline.
// ----------------------------------------------------------------------------
package c2s_pkg;

    // cordic stages, 8 to 24
    localparam int ITERATIONS = 16;

    // integer square root steps for a 29-bit radicand (2 bits per step)
    localparam int SQRT_STEPS = 15;
    localparam int SQRT_W     = 30;

    // cordic datapath and angle widths
    localparam int CW = 34;
    localparam int AW = 26;

    // valid pipeline: input, square, sqrt steps, cordic setup, cordic, output
    localparam int PIPE_DEPTH = 2 + SQRT_STEPS + 1 + ITERATIONS + 1;

    localparam logic signed [AW-1:0] PI_Q20      = AW'(3294199);
    localparam logic signed [AW-1:0] TWO_PI_Q20  = AW'(6588397);
    localparam logic signed [AW-1:0] ROUND_HALF  = AW'(64);
    localparam int                   LONG_MAX_Q13 = 51471;
    localparam int                   LAT_MAX_Q13  = 12868;
    localparam logic signed [15:0]   ONE_Q14      = 16'sd16384;
    localparam logic signed [15:0]   NEG_ONE_Q14  = -16'sd16384;

    typedef logic signed [CW-1:0] cdat_t;
    typedef logic signed [AW-1:0] ang_t;
    typedef logic [SQRT_W-1:0]    sq_t;

    // round(atan(2^-i) * 2^20); entry 1 holds 489370 where that gives 486170
    function automatic ang_t atan_q20(input int i);
        ang_t a;
        case (i)
            0:       a = AW'(823550);
            1:       a = AW'(489370);
            2:       a = AW'(256879);
            3:       a = AW'(130396);
            4:       a = AW'(65451);
            5:       a = AW'(32757);
            6:       a = AW'(16383);
            7:       a = AW'(8192);
            8:       a = AW'(4096);
            9:       a = AW'(2048);
            10:      a = AW'(1024);
            11:      a = AW'(512);
            12:      a = AW'(256);
            13:      a = AW'(128);
            14:      a = AW'(64);
            15:      a = AW'(32);
            16:      a = AW'(16);
            17:      a = AW'(8);
            18:      a = AW'(4);
            19:      a = AW'(2);
            20:      a = AW'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== hdl/cartesian_to_spherical.sv =====
// throughput: one item per cycle; busy is never raised, the pipeline has no stall
// depth is set by the 15 square root steps and the 16 cordic stages
// reset: rst_n clears all valid bits at once; items in flight are dropped
// results are shown for one cycle with done high and cannot be held off
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// Pipelined conversion of a Q2.14 point to longitude in Q3.13 and latitude
// in Q2.13 using an integer square root and two cordic vectoring pipelines.
// ----------------------------------------------------------------------------
module cartesian_to_spherical
    import c2s_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    output logic               done,
    output logic [15:0]        longitude,
    output logic signed [14:0] latitude,
    output logic               radius_zero
);

    logic [PIPE_DEPTH-1:0] valid_reg;

    // input stage
    logic signed [15:0] in_x_reg, in_y_reg, in_z_reg;
    logic               in_rz_reg;
    logic signed [15:0] zsat_next;

    // square root stages, index 0 is the radicand stage
    sq_t                sq_v_reg [0:SQRT_STEPS];
    sq_t                sq_r_reg [0:SQRT_STEPS];
    logic signed [15:0] sq_x_reg [0:SQRT_STEPS];
    logic signed [15:0] sq_y_reg [0:SQRT_STEPS];
    logic signed [15:0] sq_z_reg [0:SQRT_STEPS];
    logic               sq_rz_reg [0:SQRT_STEPS];
    logic signed [31:0] zsq;

    // cordic stages, index 0 is the setup stage
    cdat_t lon_x_reg [0:ITERATIONS];
    cdat_t lon_y_reg [0:ITERATIONS];
    ang_t  lon_a_reg [0:ITERATIONS];
    cdat_t lat_x_reg [0:ITERATIONS];
    cdat_t lat_y_reg [0:ITERATIONS];
    ang_t  lat_a_reg [0:ITERATIONS];
    logic  cr_rz_reg [0:ITERATIONS];

    cdat_t lon_x0, lon_y0;
    ang_t  lon_a0;

    // output stage
    ang_t               lon_w, lon_rnd, lat_rnd;
    logic [15:0]        longitude_next;
    logic signed [14:0] latitude_next;
    logic [15:0]        longitude_reg;
    logic signed [14:0] latitude_reg;
    logic               radius_zero_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], start & ~busy};
        end
    end

    always_comb
    begin
        if (pos_z > ONE_Q14)
            zsat_next = ONE_Q14;
        else if (pos_z < NEG_ONE_Q14)
            zsat_next = NEG_ONE_Q14;
        else
            zsat_next = pos_z;
    end

    always_ff @(posedge clk)
    begin
        in_x_reg  <= pos_x;
        in_y_reg  <= pos_y;
        in_z_reg  <= zsat_next;
        in_rz_reg <= (pos_x == 16'sd0) && (pos_y == 16'sd0);
    end

    // radicand 1 - z^2 in Q4.28
    assign zsq = in_z_reg * in_z_reg;

    always_ff @(posedge clk)
    begin
        sq_v_reg[0]  <= SQRT_W'(32'sd268435456 - zsq);
        sq_r_reg[0]  <= '0;
        sq_x_reg[0]  <= in_x_reg;
        sq_y_reg[0]  <= in_y_reg;
        sq_z_reg[0]  <= in_z_reg;
        sq_rz_reg[0] <= in_rz_reg;
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam sq_t BIT = sq_t'(1) << (2 * (SQRT_STEPS - 1 - k));
        sq_t trial;

        assign trial = sq_r_reg[k] + BIT;

        always_ff @(posedge clk)
        begin
            if (sq_v_reg[k] >= trial)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k] - trial;
                sq_r_reg[k+1] <= (sq_r_reg[k] >> 1) + BIT;
            end
            else
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
                sq_r_reg[k+1] <= sq_r_reg[k] >> 1;
            end
            sq_x_reg[k+1]  <= sq_x_reg[k];
            sq_y_reg[k+1]  <= sq_y_reg[k];
            sq_z_reg[k+1]  <= sq_z_reg[k];
            sq_rz_reg[k+1] <= sq_rz_reg[k];
        end
    end

    // fold the left half plane onto the right one
    always_comb
    begin
        lon_x0 = CW'(sq_x_reg[SQRT_STEPS]) <<< 14;
        lon_y0 = CW'(sq_y_reg[SQRT_STEPS]) <<< 14;
        lon_a0 = '0;
        if (sq_x_reg[SQRT_STEPS] < 16'sd0)
        begin
            lon_a0 = (sq_y_reg[SQRT_STEPS] >= 16'sd0) ? PI_Q20 : -PI_Q20;
            lon_x0 = -lon_x0;
            lon_y0 = -lon_y0;
        end
    end

    always_ff @(posedge clk)
    begin
        lon_x_reg[0] <= lon_x0;
        lon_y_reg[0] <= lon_y0;
        lon_a_reg[0] <= lon_a0;
        lat_x_reg[0] <= cdat_t'(sq_r_reg[SQRT_STEPS]) <<< 14;
        lat_y_reg[0] <= CW'(sq_z_reg[SQRT_STEPS]) <<< 14;
        lat_a_reg[0] <= '0;
        cr_rz_reg[0] <= sq_rz_reg[SQRT_STEPS];
    end

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_cordic
        localparam ang_t ATAN = atan_q20(i);

        always_ff @(posedge clk)
        begin
            if (lon_y_reg[i] > 0)
            begin
                lon_x_reg[i+1] <= lon_x_reg[i] + (lon_y_reg[i] >>> i);
                lon_y_reg[i+1] <= lon_y_reg[i] - (lon_x_reg[i] >>> i);
                lon_a_reg[i+1] <= lon_a_reg[i] + ATAN;
            end
            else if (lon_y_reg[i] < 0)
            begin
                lon_x_reg[i+1] <= lon_x_reg[i] - (lon_y_reg[i] >>> i);
                lon_y_reg[i+1] <= lon_y_reg[i] + (lon_x_reg[i] >>> i);
                lon_a_reg[i+1] <= lon_a_reg[i] - ATAN;
            end
            else
            begin
                lon_x_reg[i+1] <= lon_x_reg[i];
                lon_y_reg[i+1] <= lon_y_reg[i];
                lon_a_reg[i+1] <= lon_a_reg[i];
            end

            if (lat_y_reg[i] > 0)
            begin
                lat_x_reg[i+1] <= lat_x_reg[i] + (lat_y_reg[i] >>> i);
                lat_y_reg[i+1] <= lat_y_reg[i] - (lat_x_reg[i] >>> i);
                lat_a_reg[i+1] <= lat_a_reg[i] + ATAN;
            end
            else if (lat_y_reg[i] < 0)
            begin
                lat_x_reg[i+1] <= lat_x_reg[i] - (lat_y_reg[i] >>> i);
                lat_y_reg[i+1] <= lat_y_reg[i] + (lat_x_reg[i] >>> i);
                lat_a_reg[i+1] <= lat_a_reg[i] - ATAN;
            end
            else
            begin
                lat_x_reg[i+1] <= lat_x_reg[i];
                lat_y_reg[i+1] <= lat_y_reg[i];
                lat_a_reg[i+1] <= lat_a_reg[i];
            end

            cr_rz_reg[i+1] <= cr_rz_reg[i];
        end
    end

    // wrap, round half up to Q3.13 and Q2.13 and saturate
    always_comb
    begin
        lon_w = lon_a_reg[ITERATIONS];
        if (lon_w < 0)
            lon_w = lon_w + TWO_PI_Q20;
        lon_rnd = (lon_w + ROUND_HALF) >>> 7;
        lat_rnd = (lat_a_reg[ITERATIONS] + ROUND_HALF) >>> 7;

        if (cr_rz_reg[ITERATIONS] || lon_rnd < 0)
            longitude_next = '0;
        else if (lon_rnd > AW'(LONG_MAX_Q13))
            longitude_next = 16'(LONG_MAX_Q13);
        else
            longitude_next = lon_rnd[15:0];

        if (lat_rnd > AW'(LAT_MAX_Q13))
            latitude_next = 15'(LAT_MAX_Q13);
        else if (lat_rnd < -AW'(LAT_MAX_Q13))
            latitude_next = -15'(LAT_MAX_Q13);
        else
            latitude_next = lat_rnd[14:0];
    end

    always_ff @(posedge clk)
    begin
        longitude_reg   <= longitude_next;
        latitude_reg    <= latitude_next;
        radius_zero_reg <= cr_rz_reg[ITERATIONS];
    end

    assign done        = valid_reg[PIPE_DEPTH-1];
    assign longitude   = longitude_reg;
    assign latitude    = latitude_reg;
    assign radius_zero = radius_zero_reg;

`ifndef NO_ASSERTIONS
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(valid_reg[0], PIPE_DEPTH - 1))
        else $error("result without an item accepted at the pipeline depth");

    a_rzero_lon : assert property (@(posedge clk) disable iff (!rst_n)
        (done && radius_zero) |-> (longitude == 16'd0))
        else $error("zero radius with nonzero longitude");

    a_lon_range : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (longitude <= 16'(LONG_MAX_Q13)))
        else $error("longitude above two pi");

    a_lat_range : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (latitude <= 15'(LAT_MAX_Q13) && latitude >= -15'(LAT_MAX_Q13)))
        else $error("latitude beyond a quarter turn");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the cartesian to spherical converter: directed and random points go
// in through the start/busy handshake, each result is compared field by field
// with a bit-exact predictor of the square root and cordic arithmetic.
// ----------------------------------------------------------------------------
module tb_top;
    import c2s_pkg::*;

    localparam int  N_RANDOM    = 430;
    localparam int  IDLE_LIMIT  = 2000;
    localparam int  DRAIN_WAIT  = PIPE_DEPTH + 10;
    localparam longint PI_FIX   = 3294199;
    localparam longint TWOPI_FIX = 6588397;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } point_t;

    typedef struct {
        logic [15:0]        lon;
        logic signed [14:0] lat;
        logic               rz;
    } angles_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic               done;
    logic [15:0]        longitude;
    logic signed [14:0] latitude;
    logic               radius_zero;

    point_t  pending_points[$];
    angles_t expected_angles[$];
    int      mismatches = 0;
    int      idle_cycles = 0;
    int      gap_left;
    bit      hold_for_drain;
    bit      stim_done;

    cartesian_to_spherical DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .done(done), .longitude(longitude), .latitude(latitude),
        .radius_zero(radius_zero)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = longint'(1) << 30;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint arctan_step(int i);
        longint tbl[21];
        tbl = '{823550, 489370, 256879, 130396, 65451, 32757, 16383, 8192,
                4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
        return (i < 21) ? tbl[i] : 0;
    endfunction

    // vectoring cordic, angle in radians scaled by 2^20
    function automatic longint vector_angle(longint x, longint y);
        longint a;
        longint dx;
        longint dy;
        a = 0;
        x = x * 16384;
        y = y * 16384;
        if (x < 0)
        begin
            a = (y >= 0) ? PI_FIX : -PI_FIX;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ITERATIONS && i < 24; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                a = a + arctan_step(i);
            end
            else if (y < 0)
            begin
                x = x - dx;
                y = y + dy;
                a = a - arctan_step(i);
            end
        end
        return a;
    endfunction

    function automatic angles_t spherical_angles(point_t p);
        angles_t r;
        longint z;
        longint c;
        longint lat;
        longint lon;
        longint a;
        z = p.z;
        if (z > 16384)
            z = 16384;
        if (z < -16384)
            z = -16384;
        c = int_sqrt(longint'(16384) * 16384 - z * z);
        lat = floor_shift(vector_angle(c, z) + 64, 7);
        if (lat > LAT_MAX_Q13)
            lat = LAT_MAX_Q13;
        if (lat < -LAT_MAX_Q13)
            lat = -LAT_MAX_Q13;
        lon = 0;
        r.rz = (p.x == 0 && p.y == 0);
        if (!r.rz)
        begin
            a = vector_angle(p.x, p.y);
            if (a < 0)
                a = a + TWOPI_FIX;
            lon = floor_shift(a + 64, 7);
            if (lon < 0)
                lon = 0;
            if (lon > LONG_MAX_Q13)
                lon = LONG_MAX_Q13;
        end
        r.lon = lon[15:0];
        r.lat = lat[14:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50)
            return 0;
        if (k < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [15:0] rand_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7)
            return 16'($signed($urandom_range(0, 32768)) - 16384);
        if (k < 9)
            return 16'($urandom);
        return 16'($signed($urandom_range(0, 8)) - 4);
    endfunction

    task automatic add_point(int x, int y, int z);
        point_t p;
        p.x = 16'(x);
        p.y = 16'(y);
        p.z = 16'(z);
        pending_points.push_back(p);
    endtask

    initial
    begin
        point_t p;
        add_point(0, 0, 0);
        add_point(0, 0, 16384);
        add_point(0, 0, -16384);
        add_point(16384, 0, 0);
        add_point(-16384, 0, 0);
        add_point(0, 16384, 0);
        add_point(0, -16384, 0);
        add_point(16384, -1, 0);
        add_point(16384, 1, 0);
        add_point(-32768, 0, 32767);
        add_point(32767, 32767, -32768);
        add_point(-32768, -32768, 20000);
        add_point(-1, -1, -20000);
        add_point(11585, 11585, 11585);
        add_point(-11585, -11585, -11585);
        add_point(1, 0, 16383);
        add_point(0, 1, -16383);
        add_point(-1, 0, 1);
        add_point(-16384, -1, -1);
        add_point(16'h5555, 16'hAAAA, 16'h5555);
        add_point(16'hAAAA, 16'h5555, 16'hAAAA);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            p.x = rand_coord();
            p.y = rand_coord();
            p.z = rand_coord();
            pending_points.push_back(p);
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        point_t p;
        if (!rst_n)
        begin
            start <= 1'b0;
            pos_x <= '0;
            pos_y <= '0;
            pos_z <= '0;
            gap_left = 0;
            hold_for_drain = 1'b0;
            stim_done = 1'b0;
        end
        else
        begin
            if (start && !busy)
                expected_angles.push_back(spherical_angles('{pos_x, pos_y, pos_z}));
            if (start && busy)
                ; // keep the item on the ports
            else if (hold_for_drain && expected_angles.size() != 0)
                start <= 1'b0;
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_points.size() == 0)
            begin
                start <= 1'b0;
                stim_done = 1'b1;
            end
            else
            begin
                hold_for_drain = 1'b0;
                // pause once until the pipeline has emptied
                if (pending_points.size() == 200)
                    hold_for_drain = 1'b1;
                p = pending_points.pop_front();
                start <= 1'b1;
                pos_x <= p.x;
                pos_y <= p.y;
                pos_z <= p.z;
                gap_left = pick_gap();
                if ($urandom_range(0, 3) == 0)
                    gap_left = 0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        angles_t want;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (done)
            begin
                if (expected_angles.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result lon=%0d lat=%0d rz=%0b",
                                 longitude, latitude, radius_zero);
                end
                else
                begin
                    want = expected_angles.pop_front();
                    if (longitude !== want.lon || latitude !== want.lat ||
                        radius_zero !== want.rz)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: lon %0d/%0d lat %0d/%0d rz %0b/%0b",
                                     want.lon, longitude, want.lat, latitude,
                                     want.rz, radius_zero);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        while (!(stim_done && expected_angles.size() == 0) && idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
        end
        else
        begin
            repeat (DRAIN_WAIT) @(posedge clk);
            if (mismatches == 0 && expected_angles.size() == 0)
                $display("Verification passed");
            else
                $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/c2s_pkg.sv
hdl/cartesian_to_spherical.sv
verif/tb_top.sv
